/* rtl/hyperloglog_cardinality_sketch_top_macros.svh */
// ----------------------------------------------------------------------------
// hll assertion macros
// shared property shapes for the sketch checkers
// ----------------------------------------------------------------------------
`ifndef HYPERLOGLOG_CARDINALITY_SKETCH_TOP_MACROS_SVH
`define HYPERLOGLOG_CARDINALITY_SKETCH_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HLL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hll check failed");

// next-cycle implication, sampled on clk, off during reset
`define HLL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hll check failed");

`endif

/* rtl/hll_pkg.sv */
// ----------------------------------------------------------------------------
// hll_pkg
// word types and fixed constants of the cardinality sketch
// ----------------------------------------------------------------------------
package hll_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_MERGE  = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] hash_value;
        logic [9:0]  merge_index;
        logic [5:0]  merge_rank;
    } req_word_t;

    typedef struct packed {
        logic [63:0] estimate;
        logic        linear_counted;
    } rsp_word_t;

    typedef struct packed {
        logic done;
        logic over;
        logic rem_nz;
    } div_status_t;

endpackage

/* rtl/hll_ram.sv */
// ----------------------------------------------------------------------------
// hll_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module hll_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/hll_mul64.sv */
// ----------------------------------------------------------------------------
// hll_mul64
// 64 x 64 multiplier over four 32 x 32 partial products
// ----------------------------------------------------------------------------
module hll_mul64 (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [63:0]   a,
    input  logic [63:0]   b,
    output logic          done,
    output logic [127:0]  product
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  prod_reg;
    logic [6:0]   sh_reg;
    logic [127:0] acc_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [6:0]   sh;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                pa = a_reg[31:0];
                pb = b_reg[31:0];
                sh = 7'd0;
            end
            2'd1:
            begin
                pa = a_reg[31:0];
                pb = b_reg[63:32];
                sh = 7'd32;
            end
            2'd2:
            begin
                pa = a_reg[63:32];
                pb = b_reg[31:0];
                sh = 7'd32;
            end
            default:
            begin
                pa = a_reg[63:32];
                pb = b_reg[63:32];
                sh = 7'd64;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg + 3'd1;
            busy_reg <= (cnt_reg != 3'd4);
            done_reg <= (cnt_reg == 3'd4);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                prod_reg <= {32'd0, pa} * {32'd0, pb};
                sh_reg   <= sh;
            end
            if (cnt_reg != 3'd0)
            begin
                acc_reg <= acc_reg + ({64'd0, prod_reg} << sh_reg);
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* rtl/hll_div.sv */
// ----------------------------------------------------------------------------
// hll_div
// 128-bit restoring divider, one quotient bit per cycle, saturating at 64 bits
// ----------------------------------------------------------------------------
module hll_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [127:0]         dividend,
    input  logic [127:0]         divisor,
    output hll_pkg::div_status_t status,
    output logic [63:0]          quotient
);

    logic [127:0] q_reg;
    logic [127:0] rem_reg;
    logic [127:0] d_reg;
    logic [6:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [128:0] rem_sh;
    logic [128:0] diff;
    logic         ge;

    always_comb
    begin
        rem_sh = {rem_reg, q_reg[127]};
        diff   = rem_sh - {1'b0, d_reg};
        ge     = !diff[128];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 7'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= 7'd0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg + 7'd1;
            busy_reg <= (cnt_reg != 7'd127);
            done_reg <= (cnt_reg == 7'd127);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= 128'd0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[126:0], ge};
            rem_reg <= ge ? diff[127:0] : rem_sh[127:0];
        end
    end

    assign status.done   = done_reg;
    assign status.over   = |q_reg[127:64];
    assign status.rem_nz = |rem_reg;
    assign quotient      = status.over ? {64{1'b1}} : q_reg[63:0];

endmodule

/* rtl/hyperloglog_cardinality_sketch_top.sv */
// ----------------------------------------------------------------------------
// hyperloglog_cardinality_sketch_top
// hyperloglog sketch over 2^INDEX_BITS rank registers held in one ram
// ----------------------------------------------------------------------------
// after reset the block runs a clearing pass, one ram entry a cycle, with
// req_stall high. insert and merge words then go at one word per cycle while
// no query is in progress: the rank ram is read at the accepting edge and
// written back in the next cycle, the last write being forwarded to a
// following word on the same entry. a query stalls the request side until
// its result is in the output register: a sweep through the ram port, the
// bit-serial divider, and when linear counting applies 33 passes through the
// shared 64 x 64 multiplier (32 squarings for log2, one final scale by ln2).
// the result sits in an output register, so inserts continue while it waits
// to be taken.
// ----------------------------------------------------------------------------
module hyperloglog_cardinality_sketch_top #(
    parameter int INDEX_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  hll_pkg::req_word_t req_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output hll_pkg::rsp_word_t rsp_word
);

    localparam int K  = 1 << INDEX_BITS;
    localparam int W  = 64 - INDEX_BITS;
    localparam int ZW = 65 + INDEX_BITS;  // sum of 2^-rank, 64 fraction bits
    localparam int CW = INDEX_BITS + 1;   // counts up to k

    // alpha in q32, table values for the small sketches
    localparam logic [63:0] ALPHA_Q32 =
        (K == 16) ? 64'd2890512990 :
        (K == 32) ? 64'd2993592205 :
        (K == 64) ? 64'd3045131813 :
        ((64'd7213 * 64'(K)) << 32) / (64'd10 * (64'd1000 * 64'(K) + 64'd1079));
    localparam logic [63:0] NUM       = ALPHA_Q32 * 64'(K) * 64'(K);
    localparam logic [63:0] LIM       = 64'((5 * K) / 2);
    localparam logic [5:0]  RANK_FULL = 6'(W + 1);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_SWEEP   = 8'b0000_0100,
        S_DIV     = 8'b0000_1000,
        S_LOGINIT = 8'b0001_0000,
        S_LOGSQ   = 8'b0010_0000,
        S_LNMUL   = 8'b0100_0000,
        S_FIN     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // clearing pass and sweep counters
    logic [CW-1:0] clr_idx_reg, clr_idx_next;
    logic [CW-1:0] sweep_idx_reg, sweep_idx_next;
    logic          rd_pend_reg, rd_pend_next;

    // update stage and write forwarding
    logic                  s1_valid_reg, s1_valid_next;
    logic [INDEX_BITS-1:0] s1_idx_reg, s1_idx_next;
    logic [5:0]            s1_rank_reg, s1_rank_next;
    logic                  fw_valid_reg, fw_valid_next;
    logic [INDEX_BITS-1:0] fw_idx_reg, fw_idx_next;
    logic [5:0]            fw_val_reg, fw_val_next;

    // query datapath
    logic [ZW-1:0] z_reg, z_next;
    logic [CW-1:0] zeros_reg, zeros_next;
    logic [63:0]   x_reg, x_next;
    logic [63:0]   res_reg, res_next;
    logic [4:0]    round_reg, round_next;
    logic [63:0]   est_reg, est_next;
    logic          lc_reg, lc_next;

    logic               rsp_valid_reg, rsp_valid_next;
    hll_pkg::rsp_word_t rsp_word_reg, rsp_word_next;

    // ram ports
    logic                  wr_en;
    logic [INDEX_BITS-1:0] wr_addr;
    logic [5:0]            wr_data;
    logic [INDEX_BITS-1:0] rd_addr;
    logic [5:0]            rd_data;

    // units
    logic                 div_start;
    hll_pkg::div_status_t div_status;
    logic [63:0]          div_q;
    logic                 mul_start;
    logic [63:0]          mul_a;
    logic [63:0]          mul_b;
    logic                 mul_done;
    logic [127:0]         mul_prod;

    // request decode
    logic                  req_fire;
    logic [63:0]           rest;
    logic [5:0]            tz;
    logic [5:0]            ins_rank;
    logic [25:0]           merge_ext;
    logic [INDEX_BITS-1:0] up_idx;
    logic [5:0]            up_rank;
    logic                  is_update;

    // helpers
    logic [5:0]    old_rank;
    logic          s1_write;
    logic [ZW-1:0] term;
    logic          small_range;
    logic [4:0]    lg_n;
    logic [63:0]   x_init;
    logic [63:0]   xn;
    logic [63:0]   x_upd;
    logic [63:0]   res_upd;
    logic [63:0]   kd;
    logic          sq_last;

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;

    // rank of an insert: trailing zeros of the bits above the index, plus one
    always_comb
    begin
        rest = req_word.hash_value >> INDEX_BITS;
        tz   = 6'd0;
        for (int i = 63; i >= 0; i--)
        begin
            if (rest[i])
            begin
                tz = 6'(i);
            end
        end
        ins_rank  = (rest == 64'd0) ? RANK_FULL : tz + 6'd1;
        merge_ext = 26'(req_word.merge_index);
        is_update = req_fire && ((req_word.action == hll_pkg::ACT_INSERT) ||
                                 (req_word.action == hll_pkg::ACT_MERGE));
        if (req_word.action == hll_pkg::ACT_MERGE)
        begin
            up_idx  = merge_ext[INDEX_BITS-1:0];
            up_rank = req_word.merge_rank;
        end
        else
        begin
            up_idx  = req_word.hash_value[INDEX_BITS-1:0];
            up_rank = ins_rank;
        end
    end

    // update stage compares against the forwarded last write when it hits
    assign old_rank = (fw_valid_reg && (fw_idx_reg == s1_idx_reg)) ? fw_val_reg : rd_data;
    assign s1_write = s1_valid_reg && (s1_rank_reg > old_rank);

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg[INDEX_BITS-1:0];
            wr_data = 6'd0;
        end
        else
        begin
            wr_en   = s1_write;
            wr_addr = s1_idx_reg;
            wr_data = s1_rank_reg;
        end
        rd_addr = (state_reg == S_SWEEP) ? sweep_idx_reg[INDEX_BITS-1:0] : up_idx;
    end

    // 2^-rank in q64, a zero register counts as one
    assign term = ZW'(1) << (7'd64 - {1'b0, rd_data});

    // log2 datapath around the shared multiplier
    always_comb
    begin
        lg_n = 5'd0;
        for (int i = 0; i < CW; i++)
        begin
            if (zeros_reg[i])
            begin
                lg_n = 5'(i);
            end
        end
        x_init  = 64'(zeros_reg) << (6'd62 - {1'b0, lg_n});
        xn      = mul_prod[125:62];
        x_upd   = xn[63] ? (xn >> 1) : xn;
        res_upd = xn[63] ? (res_reg | (64'd1 << (5'd31 - round_reg))) : res_reg;
        kd      = ((64'(INDEX_BITS) << 32) - res_upd) << INDEX_BITS;
        sq_last = (round_reg == 5'd31);
        small_range = !div_status.over && ((div_q < LIM) ||
                                           ((div_q == LIM) && !div_status.rem_nz));
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        sweep_idx_next = sweep_idx_reg;
        rd_pend_next   = 1'b0;
        s1_valid_next  = is_update;
        s1_idx_next    = up_idx;
        s1_rank_next   = up_rank;
        fw_valid_next  = s1_write;
        fw_idx_next    = s1_idx_reg;
        fw_val_next    = s1_rank_reg;
        z_next         = z_reg;
        zeros_next     = zeros_reg;
        x_next         = x_reg;
        res_next       = res_reg;
        round_next     = round_reg;
        est_next       = est_reg;
        lc_next        = lc_reg;
        div_start      = 1'b0;
        mul_start      = 1'b0;
        mul_a          = x_init;
        mul_b          = x_init;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_word_next  = rsp_word_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + CW'(1);
                if (clr_idx_reg[INDEX_BITS-1:0] == {INDEX_BITS{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire && (req_word.action == hll_pkg::ACT_QUERY))
                begin
                    state_next     = S_SWEEP;
                    sweep_idx_next = '0;
                    z_next         = '0;
                    zeros_next     = '0;
                end
            end
            S_SWEEP:
            begin
                if (sweep_idx_reg != CW'(K))
                begin
                    sweep_idx_next = sweep_idx_reg + CW'(1);
                    rd_pend_next   = 1'b1;
                end
                if (rd_pend_reg)
                begin
                    z_next = z_reg + term;
                    if (rd_data == 6'd0)
                    begin
                        zeros_next = zeros_reg + CW'(1);
                    end
                end
                else if (sweep_idx_reg == CW'(K))
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    if (small_range && (zeros_reg != '0))
                    begin
                        state_next = S_LOGINIT;
                    end
                    else
                    begin
                        est_next   = div_q;
                        lc_next    = 1'b0;
                        state_next = S_FIN;
                    end
                end
            end
            S_LOGINIT:
            begin
                x_next     = x_init;
                res_next   = 64'(lg_n) << 32;
                round_next = 5'd0;
                mul_start  = 1'b1;
                state_next = S_LOGSQ;
            end
            S_LOGSQ:
            begin
                mul_a = x_upd;
                mul_b = sq_last ? hll_pkg::LN2_Q64 : x_upd;
                if (sq_last)
                begin
                    mul_a = kd;
                end
                if (mul_done)
                begin
                    x_next     = x_upd;
                    res_next   = res_upd;
                    round_next = round_reg + 5'd1;
                    mul_start  = 1'b1;
                    if (sq_last)
                    begin
                        state_next = S_LNMUL;
                    end
                end
            end
            S_LNMUL:
            begin
                if (mul_done)
                begin
                    est_next   = 64'(mul_prod[127:96]);
                    lc_next    = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next               = 1'b1;
                    rsp_word_next.estimate       = est_reg;
                    rsp_word_next.linear_counted = lc_reg;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            sweep_idx_reg <= '0;
            rd_pend_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            fw_valid_reg  <= 1'b0;
            round_reg     <= 5'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            sweep_idx_reg <= sweep_idx_next;
            rd_pend_reg   <= rd_pend_next;
            s1_valid_reg  <= s1_valid_next;
            fw_valid_reg  <= fw_valid_next;
            round_reg     <= round_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= s1_idx_next;
        s1_rank_reg  <= s1_rank_next;
        fw_idx_reg   <= fw_idx_next;
        fw_val_reg   <= fw_val_next;
        z_reg        <= z_next;
        zeros_reg    <= zeros_next;
        x_reg        <= x_next;
        res_reg      <= res_next;
        est_reg      <= est_next;
        lc_reg       <= lc_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    hll_ram #(
        .WIDTH (6),
        .DEPTH (K)
    ) u_rank_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // numerator alpha*k*k in q32, scaled by 2^32 against the q64 sum
    hll_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({32'd0, NUM, 32'd0}),
        .divisor  (128'(z_reg)),
        .status   (div_status),
        .quotient (div_q)
    );

    hll_mul64 u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

endmodule

/* rtl/hll_checker.sv */
// ----------------------------------------------------------------------------
// hll_checker
// port-level checks of the sketch, bound to the top level
// ----------------------------------------------------------------------------
`include "hyperloglog_cardinality_sketch_top_macros.svh"

module hll_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input hll_pkg::req_word_t req_word,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input hll_pkg::rsp_word_t rsp_word
);

    // a held result word stays put
    `HLL_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

    // a query blocks further requests while it runs
    `HLL_ASSERT_NEXT(a_query_stalls, req_valid && !req_stall && (req_word.action == hll_pkg::ACT_QUERY), req_stall)

    // a new result only comes out of a query in progress
    `HLL_ASSERT_NOW(a_rsp_from_query, $rose(rsp_valid), $past(req_stall))

    // linear counting values stay below 2^32
    `HLL_ASSERT_NOW(a_lc_range, rsp_valid && rsp_word.linear_counted, rsp_word.estimate[63:32] == 32'd0)

endmodule

bind hyperloglog_cardinality_sketch_top hll_checker u_hll_checker (.*);

/* dv/tb_hyperloglog_cardinality_sketch_top.sv */
// ----------------------------------------------------------------------------
// tb_hyperloglog_cardinality_sketch_top
// drives insert, merge and query words into the sketch with random idling,
// keeps its own copy of the rank registers, and checks every estimate
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hyperloglog_cardinality_sketch_top;

    localparam int INDEX_BITS = 10;
    localparam int REG_COUNT = 1 << INDEX_BITS;
    localparam int REST_BITS = 64 - INDEX_BITS;
    // action code that the block must ignore
    localparam logic [1:0] ACT_IDLE = 2'd3;
    localparam int RANDOM_WORDS = 1450;
    localparam int CYCLE_LIMIT = 10000000;

    // sketch model and store of pending estimates
    class estimate_board;
        bit [5:0]           ranks[REG_COUNT];
        hll_pkg::rsp_word_t pending_estimates[$];
        int                 mismatches;
        int                 checked;

        function bit [63:0] log2_q32(bit [63:0] v);
            int         n;
            bit [63:0]  x;
            bit [63:0]  res;
            bit [127:0] p;
            n = 0;
            while (n < 63 && (v >> (n + 1)) != 0)
                n++;
            x = v << (62 - n);
            res = 64'(n) << 32;
            for (int i = 0; i < 32; i++)
            begin
                p = 128'(x) * 128'(x);
                x = p[125:62];
                if (x[63])
                begin
                    x = x >> 1;
                    res[31 - i] = 1'b1;
                end
            end
            return res;
        endfunction

        function hll_pkg::rsp_word_t estimate_now();
            bit [127:0]         z;
            bit [127:0]         numer;
            bit [127:0]         quot;
            bit [63:0]          alpha;
            bit [63:0]          k;
            bit [63:0]          zeros;
            bit [63:0]          lim;
            bit [63:0]          d;
            bit [127:0]         prod;
            bit                 over;
            bit                 rem_nz;
            bit                 small_range;
            hll_pkg::rsp_word_t r;
            z = '0;
            zeros = '0;
            k = 64'(REG_COUNT);
            foreach (ranks[i])
            begin
                if (ranks[i] == 0)
                begin
                    z += 128'(1) << 64;
                    zeros++;
                end
                else
                    z += 128'(1) << (64 - ranks[i]);
            end
            if (k == 16) alpha = 64'd2890512990;
            else if (k == 32) alpha = 64'd2993592205;
            else if (k == 64) alpha = 64'd3045131813;
            else alpha = ((64'd7213 * k) << 32) / (64'd10 * (64'd1000 * k + 64'd1079));
            numer = 128'(alpha * k * k) << 32;
            quot = numer / z;
            rem_nz = (numer % z) != 0;
            over = quot[127:64] != 0;
            lim = (64'd5 * k) / 64'd2;
            small_range = !over && (quot[63:0] < lim || (quot[63:0] == lim && !rem_nz));
            if (small_range && zeros != 0)
            begin
                d = (64'(INDEX_BITS) << 32) - log2_q32(zeros);
                prod = 128'(k * d) * 128'(hll_pkg::LN2_Q64);
                r.estimate = 64'(prod[127:96]);
                r.linear_counted = 1'b1;
            end
            else
            begin
                r.estimate = over ? '1 : quot[63:0];
                r.linear_counted = 1'b0;
            end
            return r;
        endfunction

        function void note(hll_pkg::req_word_t w);
            bit [63:0] rest;
            bit [5:0]  rank;
            int        idx;
            case (w.action)
                hll_pkg::ACT_INSERT:
                begin
                    idx = int'(w.hash_value & (REG_COUNT - 1));
                    rest = w.hash_value >> INDEX_BITS;
                    rank = 6'd1;
                    if (rest == 0)
                        rank = 6'(REST_BITS + 1);
                    else
                        while (!rest[0])
                        begin
                            rest = rest >> 1;
                            rank++;
                        end
                    if (ranks[idx] < rank) ranks[idx] = rank;
                end
                hll_pkg::ACT_MERGE:
                begin
                    idx = int'(w.merge_index) & (REG_COUNT - 1);
                    if (ranks[idx] < w.merge_rank) ranks[idx] = w.merge_rank;
                end
                hll_pkg::ACT_QUERY: pending_estimates.push_back(estimate_now());
                default: ;
            endcase
        endfunction

        function void check(hll_pkg::rsp_word_t r);
            hll_pkg::rsp_word_t e;
            checked++;
            if (pending_estimates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: estimate=%0d linear=%0b",
                             r.estimate, r.linear_counted);
                return;
            end
            e = pending_estimates.pop_front();
            if (r.estimate !== e.estimate || r.linear_counted !== e.linear_counted)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: estimate exp %0d got %0d, linear exp %0b got %0b",
                             checked, e.estimate, r.estimate, e.linear_counted,
                             r.linear_counted);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    hll_pkg::req_word_t req_word;
    logic               rsp_valid;
    logic               rsp_stall;
    hll_pkg::rsp_word_t rsp_word;

    estimate_board board;
    bit            quiet;        // no idling on either side in the closing stretch
    int            cycles;

    hyperloglog_cardinality_sketch_top #(
        .INDEX_BITS(INDEX_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_word (req_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word (rsp_word)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // cycle counter and timeout guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // results are taken at the rising edge; the dut updates with nonblocking
    // assignments so the values seen here are the ones before the edge
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check(rsp_word);
    end

    // receiver back-pressure: random stall bursts, changed at negedge
    initial
    begin
        int burst;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 19);
                rsp_stall = 1'b1;
                repeat (burst - 1) @(negedge clk);
            end
            else
                rsp_stall = 1'b0;
        end
    end

    // one word on the request side; called at a falling edge, returns at the
    // falling edge after the accepting rising edge with valid still high
    task automatic send_word(hll_pkg::req_word_t w);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid = 1'b1;
        req_word = w;
        forever
        begin
            @(posedge clk);
            if (!req_stall)
                break;
        end
        board.note(w);
        @(negedge clk);
    endtask

    function automatic hll_pkg::req_word_t make_word(bit [1:0] act, bit [63:0] h,
                                                     bit [9:0] idx, bit [5:0] rank);
        hll_pkg::req_word_t w;
        w.action = act;
        w.hash_value = h;
        w.merge_index = idx;
        w.merge_rank = rank;
        return w;
    endfunction

    // random word: mostly inserts and merges, queries now and then, rare ignored codes
    function automatic hll_pkg::req_word_t random_word();
        int        pick;
        bit [63:0] h;
        bit [5:0]  rank;
        pick = $urandom_range(0, 99);
        h = {$urandom, $urandom};
        // push zeros into the low end of the rank field so deep ranks show up
        if ($urandom_range(0, 3) == 0)
            h = {h[63:INDEX_BITS] << $urandom_range(0, 55), h[INDEX_BITS-1:0]};
        rank = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(40, 63))
                                            : 6'($urandom_range(0, 63));
        if (pick < 44)
            return make_word(hll_pkg::ACT_INSERT, h, 10'($urandom), 6'($urandom));
        else if (pick < 95)
            return make_word(hll_pkg::ACT_MERGE, h, 10'($urandom), rank);
        else if (pick < 98)
            return make_word(hll_pkg::ACT_QUERY, h, 10'($urandom), 6'($urandom));
        else
            return make_word(ACT_IDLE, h, 10'($urandom), 6'($urandom));
    endfunction

    initial
    begin
        board = new();
        quiet = 1'b0;
        cycles = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_word = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty sketch, field extremes, deepest ranks, ignored code
        send_word(make_word(hll_pkg::ACT_QUERY, '0, '0, '0));
        send_word(make_word(hll_pkg::ACT_INSERT, 64'h0, '0, '0));
        send_word(make_word(hll_pkg::ACT_INSERT, '1, '1, '1));
        send_word(make_word(hll_pkg::ACT_INSERT, 64'h8000_0000_0000_0001, '0, '0));
        send_word(make_word(hll_pkg::ACT_INSERT, 64'h0000_0000_0000_0400, '0, '0));
        send_word(make_word(hll_pkg::ACT_QUERY, '1, '1, '1));
        send_word(make_word(hll_pkg::ACT_MERGE, '0, 10'h3FF, 6'd63));
        send_word(make_word(hll_pkg::ACT_MERGE, '1, 10'h000, 6'd0));
        send_word(make_word(hll_pkg::ACT_MERGE, '0, 10'h155, 6'd56));
        send_word(make_word(hll_pkg::ACT_MERGE, '0, 10'h155, 6'd20));
        send_word(make_word(hll_pkg::ACT_MERGE, '0, 10'h2AA, 6'd61));
        send_word(make_word(ACT_IDLE, '1, '1, '1));
        send_word(make_word(ACT_IDLE, '0, '0, '0));
        send_word(make_word(hll_pkg::ACT_QUERY, '0, '0, '0));
        // successive updates to one register exercise the forwarding path
        send_word(make_word(hll_pkg::ACT_INSERT, 64'h0000_0000_0001_0005, '0, '0));
        send_word(make_word(hll_pkg::ACT_MERGE, '0, 10'd5, 6'd3));
        send_word(make_word(hll_pkg::ACT_INSERT, 64'h0000_0000_0000_0C05, '0, '0));
        send_word(make_word(hll_pkg::ACT_QUERY, '0, '0, '0));

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS - RANDOM_WORDS / 8)
                quiet = 1'b1;
            send_word(random_word());
        end
        send_word(make_word(hll_pkg::ACT_QUERY, '0, '0, '0));
        req_valid = 1'b0;

        // drain outstanding estimates, then a short tail for stray results
        while (board.pending_estimates.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
